FILE: rtl/cfb_pkg.sv
// Shared types and constants for the cascaded FIR band-pass filter.
package cfb_pkg;

  // Request operation codes.
  localparam int OPCODE_BITS = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_FILTER  = 2'd0,
    OP_LOAD_HP = 2'd1,
    OP_LOAD_LP = 2'd2
  } opcode_t;

  // Tap-count register: width and value after reset.
  localparam int                   CFG_BITS   = 10;
  localparam logic [CFG_BITS-1:0]  TAPS_RESET = 10'd402;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic clear;       // zero the accumulator
    logic data_valid;  // memory read data holds a coefficient and a sample
    logic round;       // round and saturate the finished sum
  } mac_ctrl_t;

endpackage

FILE: rtl/cfb_in_if.sv
// Request channel: operation, channel, coefficient load and sample payload.
interface cfb_in_if #(
  parameter int CH_W        = 1,
  parameter int TI_W        = 9,
  parameter int COEF_BITS   = 18,
  parameter int SAMPLE_BITS = 24
);
  import cfb_pkg::*;

  logic                          valid;
  logic                          ready;
  opcode_t                       opcode;
  logic [CH_W-1:0]               channel;
  logic [TI_W-1:0]               tap_index;
  logic signed [COEF_BITS-1:0]   coefficient;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (
    output valid, opcode, channel, tap_index, coefficient, sample,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, tap_index, coefficient, sample,
    output ready
  );

endinterface

FILE: rtl/cfb_out_if.sv
// Result channel: channel, filtered sample and saturation flag.
interface cfb_out_if #(
  parameter int CH_W        = 1,
  parameter int SAMPLE_BITS = 24
);
  import cfb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CH_W-1:0]               out_channel;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;

  modport source (
    output valid, out_channel, filtered, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_channel, filtered, saturated,
    output ready
  );

endinterface

FILE: rtl/cfb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port: the data for an address appears in the next cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cfb_mac.sv
// Shared multiply-accumulate unit with rounding and saturation for both stages.
module cfb_mac #(
  parameter int MAX_TAPS    = 512,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfb_pkg::mac_ctrl_t            ctrl,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i,
  output logic signed [SAMPLE_BITS-1:0] y_o,
  output logic                          clip_o
);
  import cfb_pkg::*;

  // The exact sum of MAX_TAPS products fits in RAW_W bits. Beyond 64 bits the
  // running sum is clamped to +-2^62 after every addition.
  localparam int  P_W        = SAMPLE_BITS + COEF_BITS;
  localparam int  RAW_W      = P_W + $clog2(MAX_TAPS);
  localparam bit  NEED_CLAMP = (RAW_W > 64);
  localparam int  ACC_W      = NEED_CLAMP ? 64 : RAW_W;
  localparam int  COEF_FRAC  = COEF_BITS - 2;

  localparam logic signed [ACC_W-1:0] ACC_ONE  = 1;
  localparam logic signed [ACC_W-1:0] ACC_HI   = ACC_ONE <<< 62;
  localparam logic signed [ACC_W-1:0] ACC_LO   = -(ACC_ONE <<< 62);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_ONE <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_HI     = (ACC_ONE <<< (SAMPLE_BITS - 1)) - ACC_ONE;
  localparam logic signed [ACC_W-1:0] Y_LO     = -(ACC_ONE <<< (SAMPLE_BITS - 1));

  logic                    prod_v_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] shifted;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic                    clip_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                    clip_r;

  // Product register between the memory read data and the adder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.data_valid;
    end
    if (ctrl.data_valid) begin
      prod_r <= coef_i * smp_i;
    end
  end

  // Accumulate with the wide-sum clamp.
  always_comb begin
    sum = acc_r + ACC_W'(prod_r);
    acc_nxt = sum;
    if (NEED_CLAMP && (sum > ACC_HI)) begin
      acc_nxt = ACC_HI;
    end else if (NEED_CLAMP && (sum < ACC_LO)) begin
      acc_nxt = ACC_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Round half up, drop the fraction bits and saturate to the sample range.
  always_comb begin
    shifted  = (acc_r + HALF_LSB) >>> COEF_FRAC;
    clip_nxt = 1'b0;
    y_nxt    = shifted[SAMPLE_BITS-1:0];
    if (shifted > Y_HI) begin
      y_nxt    = Y_HI[SAMPLE_BITS-1:0];
      clip_nxt = 1'b1;
    end else if (shifted < Y_LO) begin
      y_nxt    = Y_LO[SAMPLE_BITS-1:0];
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.round) begin
      y_r    <= y_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign y_o    = y_r;
  assign clip_o = clip_r;

endmodule

FILE: rtl/cascaded_fir_bandpass.sv
// Two-stage band-pass FIR (high-pass then low-pass) sharing one MAC over two RAMs.
// A sample request walks the taps in use (1..MAX_TAPS) in each stage, and no new request
// is taken until its result has been registered for the output. That hand-off waits
// only while an earlier result still waits. One coefficient read and one delay-line
// read per cycle feed the single MAC during a tap walk. Loads and ignored opcodes give
// no result. After reset the delay RAM is zeroed with ready low.
module cascaded_fir_bandpass #(
  parameter int MAX_TAPS    = 512,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cfb_pkg::CFG_BITS-1:0] cfg_wdata,
  cfb_in_if.sink                       in_req,
  cfb_out_if.source                    out_rsp
);
  import cfb_pkg::*;

  localparam int TI_W     = $clog2(MAX_TAPS);
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CO_DEPTH = 2 * MAX_TAPS;
  localparam int CA_W     = $clog2(CO_DEPTH);
  localparam int DL_DEPTH = 2 * CHANNELS * MAX_TAPS;
  localparam int DA_W     = $clog2(DL_DEPTH);

  localparam logic [CA_W-1:0] CO_HALF  = CA_W'(MAX_TAPS);
  localparam logic [DA_W-1:0] DL_HALF  = DA_W'(CHANNELS * MAX_TAPS);
  localparam logic [DA_W-1:0] DL_LAST  = DA_W'(DL_DEPTH - 1);
  localparam logic [DA_W-1:0] LINE_LEN = DA_W'(MAX_TAPS);
  localparam logic [TI_W-1:0] TAP_LAST = TI_W'(MAX_TAPS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_LP_WRITE,
    ST_RESULT
  } state_t;

  state_t                  state_r;
  logic [DA_W-1:0]         clr_r;
  logic [CFG_BITS-1:0]     taps_r;
  logic [TI_W-1:0]         wpos_r [CHANNELS];
  logic [CH_W-1:0]         ch_r;
  logic [TI_W-1:0]         pos_r;
  logic [DA_W-1:0]         base_r;
  logic [TI_W-1:0]         taps_m1_r;
  logic [TI_W-1:0]         k_r;
  logic [TI_W-1:0]         slot_r;
  logic                    stage_r;
  logic                    drain_r;
  logic                    rd_v_r;
  logic                    clip_r;
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [SAMPLE_BITS-1:0] out_y_r;
  logic                    out_sat_r;

  logic                    accept;
  logic [CH_W-1:0]         ch_mod;
  logic [TI_W-1:0]         ti_mod;
  logic [TI_W-1:0]         pos_cur;
  logic [DA_W-1:0]         dl_base;
  logic [TI_W-1:0]         taps_m1;

  logic                    co_we;
  logic [CA_W-1:0]         co_waddr;
  logic [CA_W-1:0]         co_raddr;
  logic [COEF_BITS-1:0]    co_rdata;
  logic                    dl_we;
  logic [DA_W-1:0]         dl_waddr;
  logic [SAMPLE_BITS-1:0]  dl_wdata;
  logic [DA_W-1:0]         dl_raddr;
  logic [SAMPLE_BITS-1:0]  dl_rdata;

  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_y;
  logic                          mac_clip;

  // Request decode: channel and tap index wrap into range.
  assign accept = in_req.valid && in_req.ready;
  assign ch_mod = (int'(in_req.channel) >= CHANNELS) ?
                  CH_W'(int'(in_req.channel) - CHANNELS) : in_req.channel;
  assign ti_mod = (int'(in_req.tap_index) >= MAX_TAPS) ?
                  TI_W'(int'(in_req.tap_index) - MAX_TAPS) : in_req.tap_index;
  assign pos_cur = wpos_r[ch_mod];
  assign dl_base = DA_W'(ch_mod) * LINE_LEN;

  // Taps in use, limited to 1..MAX_TAPS, as a last-index value.
  always_comb begin
    if (taps_r == '0) begin
      taps_m1 = '0;
    end else if (int'(taps_r) > MAX_TAPS) begin
      taps_m1 = TAP_LAST;
    end else begin
      taps_m1 = TI_W'(taps_r - 1'b1);
    end
  end

  // Coefficient RAM: high-pass in the lower half, low-pass in the upper half.
  always_comb begin
    co_we    = accept && ((in_req.opcode == OP_LOAD_HP) || (in_req.opcode == OP_LOAD_LP));
    co_waddr = ((in_req.opcode == OP_LOAD_LP) ? CO_HALF : '0) + CA_W'(ti_mod);
    co_raddr = (stage_r ? CO_HALF : '0) + CA_W'(k_r);
  end

  // Delay RAM: clearing pass, new sample, then the high-pass result.
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = clr_r;
    dl_wdata = '0;
    if (state_r == ST_CLEAR) begin
      dl_we = 1'b1;
    end else if (accept && (in_req.opcode == OP_FILTER)) begin
      dl_we    = 1'b1;
      dl_waddr = dl_base + DA_W'(pos_cur);
      dl_wdata = in_req.sample;
    end else if (state_r == ST_LP_WRITE) begin
      dl_we    = 1'b1;
      dl_waddr = DL_HALF + base_r + DA_W'(pos_r);
      dl_wdata = mac_y;
    end
    dl_raddr = (stage_r ? DL_HALF : '0) + base_r + DA_W'(slot_r);
  end

  cfb_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (CO_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (co_we),
    .waddr (co_waddr),
    .wdata (in_req.coefficient),
    .raddr (co_raddr),
    .rdata (co_rdata)
  );

  cfb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DL_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  // MAC control follows the sequencer.
  always_comb begin
    mac_ctrl.clear      = (state_r == ST_IDLE) || (state_r == ST_LP_WRITE);
    mac_ctrl.data_valid = rd_v_r;
    mac_ctrl.round      = (state_r == ST_ROUND);
  end

  cfb_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .coef_i (co_rdata),
    .smp_i  (dl_rdata),
    .y_o    (mac_y),
    .clip_o (mac_clip)
  );

  // Sequencer: clearing pass, tap walk of each stage and result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      taps_r      <= TAPS_RESET;
      wpos_r      <= '{default: '0};
      stage_r     <= 1'b0;
      drain_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        taps_r <= cfg_wdata;
      end
      rd_v_r <= (state_r == ST_RUN);
      // In the result state the hand-off below sets the valid flag.
      if (out_rsp.valid && out_rsp.ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == DL_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_req.opcode == OP_FILTER)) begin
            ch_r      <= ch_mod;
            pos_r     <= pos_cur;
            base_r    <= dl_base;
            taps_m1_r <= taps_m1;
            k_r       <= '0;
            slot_r    <= pos_cur;
            stage_r   <= 1'b0;
            state_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          k_r    <= k_r + 1'b1;
          slot_r <= (slot_r == '0) ? TAP_LAST : slot_r - 1'b1;
          if (k_r == taps_m1_r) begin
            drain_r <= 1'b0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state_r <= stage_r ? ST_RESULT : ST_LP_WRITE;
        end
        ST_LP_WRITE: begin
          clip_r  <= mac_clip;
          stage_r <= 1'b1;
          k_r     <= '0;
          slot_r  <= pos_r;
          state_r <= ST_RUN;
        end
        ST_RESULT: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_ch_r     <= ch_r;
            out_y_r      <= mac_y;
            out_sat_r    <= clip_r | mac_clip;
            wpos_r[ch_r] <= (pos_r == TAP_LAST) ? '0 : pos_r + 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Channel ports.
  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.out_channel = out_ch_r;
  assign out_rsp.filtered    = out_y_r;
  assign out_rsp.saturated   = out_sat_r;

endmodule

FILE: tb/sv/cfb_bandpass_checker.sv
// Checker for the band-pass filter: follows every request, predicts each result and compares.
module cfb_bandpass_checker #(
  parameter int MAX_TAPS    = 512,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cfb_pkg::CFG_BITS-1:0] cfg_wdata,
  cfb_in_if                            in_mon,
  cfb_out_if                           out_mon,
  output int                           fail_count,
  output int                           pending_results
);
  import cfb_pkg::*;

  localparam int     SLOT_BITS  = $clog2(MAX_TAPS);
  localparam int     COEF_FRAC  = COEF_BITS - 2;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);
  localparam longint SAMPLE_HI  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO  = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct packed {
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } filtered_sample_t;

  // Shadow copy of the filter state.
  logic [CFG_BITS-1:0]           taps_reg;
  logic signed [COEF_BITS-1:0]   hp_coef [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   lp_coef [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hp_line [CHANNELS][MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] lp_line [CHANNELS][MAX_TAPS];
  logic [SLOT_BITS-1:0]          newest_slot [CHANNELS];

  filtered_sample_t expected_samples [$];
  int               mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // One direct-form stage over the channel's line, rounded half up and clipped.
  function automatic logic signed [SAMPLE_BITS-1:0] stage_output(input bit use_lowpass,
                                                                 input int ch,
                                                                 input int taps,
                                                                 inout bit clipped);
    longint               acc;
    longint               rounded;
    logic [SLOT_BITS-1:0] slot;
    acc = 0;
    for (int k = 0; k < taps; k++) begin
      slot = newest_slot[ch] - SLOT_BITS'(k);
      if (use_lowpass) begin
        acc += longint'(lp_coef[k]) * longint'(lp_line[ch][slot]);
      end else begin
        acc += longint'(hp_coef[k]) * longint'(hp_line[ch][slot]);
      end
    end
    rounded = (acc + ROUND_HALF) >>> COEF_FRAC;
    if (rounded > SAMPLE_HI) begin
      rounded = SAMPLE_HI;
      clipped = 1'b1;
    end else if (rounded < SAMPLE_LO) begin
      rounded = SAMPLE_LO;
      clipped = 1'b1;
    end
    return SAMPLE_BITS'(rounded);
  endfunction

  // Push a sample through both stages and advance the channel's write slot.
  function automatic filtered_sample_t filter_one_sample(input int ch,
                                                         input logic signed [SAMPLE_BITS-1:0] x);
    filtered_sample_t              res;
    int                            taps;
    bit                            clipped;
    logic signed [SAMPLE_BITS-1:0] hp;
    taps    = int'(taps_reg);
    clipped = 1'b0;
    // A tap count of zero acts as one, and anything above the store size as the store size.
    if (taps < 1) begin
      taps = 1;
    end
    if (taps > MAX_TAPS) begin
      taps = MAX_TAPS;
    end
    hp_line[ch][newest_slot[ch]] = x;
    hp = stage_output(1'b0, ch, taps, clipped);
    lp_line[ch][newest_slot[ch]] = hp;
    res.filtered  = stage_output(1'b1, ch, taps, clipped);
    res.channel   = ch[0];
    res.saturated = clipped;
    newest_slot[ch] = newest_slot[ch] + 1'b1;
    return res;
  endfunction

  // Watch both channels and the register port on every edge.
  always @(posedge clk) begin
    filtered_sample_t want;
    if (!rst_n) begin
      taps_reg = TAPS_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        newest_slot[c] = '0;
        for (int k = 0; k < MAX_TAPS; k++) begin
          hp_line[c][k] = '0;
          lp_line[c][k] = '0;
        end
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
        hp_coef[k] = '0;
        lp_coef[k] = '0;
      end
      expected_samples.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result ch %0d value %0d with no request waiting",
                                    out_mon.out_channel, out_mon.filtered));
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.out_channel !== want.channel) begin
            report_mismatch($sformatf("out_channel %0d, expected %0d",
                                      out_mon.out_channel, want.channel));
          end
          if (out_mon.filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered %0d, expected %0d (ch %0d)",
                                      out_mon.filtered, want.filtered, want.channel));
          end
          if (out_mon.saturated !== want.saturated) begin
            report_mismatch($sformatf("saturated %0b, expected %0b (ch %0d)",
                                      out_mon.saturated, want.saturated, want.channel));
          end
        end
      end
      if (cfg_we === 1'b1) begin
        taps_reg = cfg_wdata;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        case (in_mon.opcode)
          OP_FILTER: begin
            expected_samples.push_back(filter_one_sample(int'(in_mon.channel) % CHANNELS,
                                                         in_mon.sample));
          end
          OP_LOAD_HP: begin
            hp_coef[in_mon.tap_index] = in_mon.coefficient;
          end
          OP_LOAD_LP: begin
            lp_coef[in_mon.tap_index] = in_mon.coefficient;
          end
          // The unused code is dropped without a result.
          default: begin
          end
        endcase
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_samples.size();
  end

endmodule

FILE: tb/sv/tb_cascaded_fir_bandpass.sv
// Testbench top for the cascaded band-pass FIR: clock, reset, requests, result stalls, verdict.
module tb_cascaded_fir_bandpass;
  import cfb_pkg::*;

  localparam int                         MAX_TAPS      = 512;
  localparam int                         FILL_TAPS     = 64;
  localparam logic [OPCODE_BITS-1:0]     OP_UNUSED     = 2'd3;
  localparam logic signed [17:0]         COEF_MAX      = 18'sh1FFFF;
  localparam logic signed [17:0]         COEF_MIN      = 18'sh20000;
  localparam logic signed [17:0]         COEF_UNITY    = 18'sh10000;
  localparam logic signed [23:0]         SAMPLE_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0]         SAMPLE_MIN    = 24'sh800000;
  localparam int                         SETTLE_CYCLES = 16;
  localparam int                         END_CYCLES    = 2 * MAX_TAPS + 16;
  localparam int                         CYCLE_LIMIT   = 600000;
  localparam int                         PHASES        = 16;
  localparam int                         PHASE_ITEMS   = 27;
  localparam int                         PHASE_TAPS [PHASES] =
    '{1, 2, 3, 5, 8, 16, 33, 64, 7, 12, 48, 4, 24, 0, 40, 61};

  typedef struct packed {
    opcode_t            opcode;
    logic               channel;
    logic [8:0]         tap_index;
    logic signed [17:0] coefficient;
    logic signed [23:0] sample;
  } filter_request_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending_results;
  int                  cycle_count = 0;

  // Idle pattern state for each side.
  int tx_run_left = 0;
  bit tx_calm     = 1'b0;
  int rx_run_left = 0;
  bit rx_calm     = 1'b0;

  cfb_in_if  #(.CH_W(1), .TI_W(9), .COEF_BITS(18), .SAMPLE_BITS(24)) in_req ();
  cfb_out_if #(.CH_W(1), .SAMPLE_BITS(24))                          out_rsp ();

  cascaded_fir_bandpass i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  cfb_bandpass_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mon          (in_req),
    .out_mon         (out_rsp),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle lengths come in runs: some runs never idle, the others draw a random idle before each item.
  task automatic draw_gap(inout int run_left, inout bit calm, output int gap);
    if (run_left == 0) begin
      run_left = $urandom_range(1, 40);
      calm     = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    gap = calm ? 0 : $urandom_range(0, 13);
  endtask

  function automatic logic signed [17:0] rand_coef();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2:    return 18'($urandom);
      7:          return '0;
      8:          return COEF_MAX;
      9:          return COEF_MIN;
      default:    return 18'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_sample();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      7:       return SAMPLE_MAX;
      8:       return SAMPLE_MIN;
      9:       return 24'($urandom_range(0, 2047) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  // Present one request after a random idle and hold it until accepted.
  task automatic send_request(input filter_request_t r);
    int gap;
    draw_gap(tx_run_left, tx_calm, gap);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.opcode      <= r.opcode;
    in_req.channel     <= r.channel;
    in_req.tap_index   <= r.tap_index;
    in_req.coefficient <= r.coefficient;
    in_req.sample      <= r.sample;
    do @(posedge clk); while (in_req.ready !== 1'b1);
  endtask

  task automatic send_load(input opcode_t op, input logic [8:0] idx,
                           input logic signed [17:0] c);
    filter_request_t r;
    r.opcode      = op;
    r.channel     = 1'($urandom);
    r.tap_index   = idx;
    r.coefficient = c;
    r.sample      = 24'($urandom);
    send_request(r);
  endtask

  task automatic send_sample(input logic ch, input logic signed [23:0] x);
    filter_request_t r;
    r.opcode      = OP_FILTER;
    r.channel     = ch;
    r.tap_index   = 9'($urandom);
    r.coefficient = 18'($urandom);
    r.sample      = x;
    send_request(r);
  endtask

  task automatic send_unused();
    filter_request_t r;
    r.opcode      = opcode_t'(OP_UNUSED);
    r.channel     = 1'($urandom);
    r.tap_index   = 9'($urandom);
    r.coefficient = 18'($urandom);
    r.sample      = 24'($urandom);
    send_request(r);
  endtask

  // Stop sending, wait for every outstanding result, then let a late load finish.
  task automatic settle();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: stall at random, take each result when it comes.
  initial begin
    int gap;
    out_rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      draw_gap(rx_run_left, rx_calm, gap);
      if (gap > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (out_rsp.valid !== 1'b1);
    end
  end

  // Request side and verdict.
  initial begin
    int eff_taps;
    int pick;
    in_req.valid       <= 1'b0;
    in_req.opcode      <= OP_FILTER;
    in_req.channel     <= 1'b0;
    in_req.tap_index   <= '0;
    in_req.coefficient <= '0;
    in_req.sample      <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the first FILL_TAPS positions of both stores; no tap count used below
    // reaches past them. The first tap is unity and the rest are mostly zero.
    for (int i = 0; i < FILL_TAPS; i++) begin
      send_load(OP_LOAD_HP, 9'(i), (i == 0) ? COEF_UNITY :
                ($urandom_range(0, 15) == 0) ? rand_coef() : 18'sd0);
      send_load(OP_LOAD_LP, 9'(i), (i == 0) ? COEF_UNITY :
                ($urandom_range(0, 15) == 0) ? rand_coef() : 18'sd0);
    end

    // Longest filter that the filled stores allow.
    write_taps(CFG_BITS'(FILL_TAPS));
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, rand_sample());

    // A tap count of zero behaves as a single tap; extreme coefficients clip.
    write_taps('0);
    send_load(OP_LOAD_HP, '0, COEF_MAX);
    send_load(OP_LOAD_LP, '0, COEF_MIN);
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, 24'sd1);
    send_load(OP_LOAD_HP, '0, COEF_UNITY);
    send_load(OP_LOAD_LP, '0, COEF_UNITY);
    send_sample(1'b0, SAMPLE_MIN);
    send_sample(1'b1, SAMPLE_MAX);
    send_sample(1'b0, -24'sd1);
    send_unused();
    send_load(OP_LOAD_HP, 9'd511, COEF_MIN);
    send_load(OP_LOAD_LP, 9'd511, COEF_MAX);

    write_taps(10'd1);
    send_sample(1'b1, -24'sd1);
    send_unused();
    send_sample(1'b0, SAMPLE_MAX);

    // Random phases over a range of tap counts within the filled positions.
    for (int p = 0; p < PHASES; p++) begin
      write_taps(CFG_BITS'(PHASE_TAPS[p]));
      eff_taps = (PHASE_TAPS[p] < 1) ? 1 : (PHASE_TAPS[p] > MAX_TAPS) ? MAX_TAPS : PHASE_TAPS[p];
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_sample(1'($urandom), rand_sample());
        end else if (pick < 94) begin
          send_load((pick < 82) ? OP_LOAD_HP : OP_LOAD_LP,
                    9'(($urandom_range(0, 1) == 0) ? $urandom_range(0, eff_taps - 1)
                                                   : $urandom_range(0, MAX_TAPS - 1)),
                    rand_coef());
        end else begin
          send_unused();
        end
        // Now and then let the pipe run dry before going on.
        if ($urandom_range(0, 63) == 0) begin
          settle();
        end
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cfb_pkg.sv
rtl/cfb_in_if.sv
rtl/cfb_out_if.sv
rtl/cfb_ram.sv
rtl/cfb_mac.sv
rtl/cascaded_fir_bandpass.sv
tb/sv/cfb_bandpass_checker.sv
tb/sv/tb_cascaded_fir_bandpass.sv
